/* sv/midi_chord_step_follower_macros.svh */
// ----------------------------------------------------------------------------
// MIDI chord step follower assertion macros
// Shared concurrent assertion forms, all clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MIDI_CHORD_STEP_FOLLOWER_MACROS_SVH
`define MIDI_CHORD_STEP_FOLLOWER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MCSF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcsf: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define MCSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcsf: next-cycle check failed");

`endif

/* sv/mcsf_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI chord step follower package
// Payload structs, internal command and header types, fixed codes.
// ----------------------------------------------------------------------------
package mcsf_pkg;

   // item func codes
   localparam logic [1:0] FUNC_MIDI   = 2'd0;
   localparam logic [1:0] FUNC_HEADER = 2'd1;
   localparam logic [1:0] FUNC_NOTE   = 2'd2;

   localparam logic [7:0] STATUS_MASK  = 8'hf0;
   localparam logic [7:0] NOTE_ON      = 8'h90;
   localparam logic [7:0] OUT_NOTE_OFF = 8'h81;
   localparam logic [7:0] OUT_NOTE_ON  = 8'h91;
   localparam logic [6:0] OUT_VELOCITY = 7'd64;
   localparam int         FRAME_LIMIT  = 4096;

   localparam int         CSR_ADDR_W       = 3;
   localparam logic [8:0] STEP_COUNT_RESET = 9'd1;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  midi_status;
      logic [6:0]  midi_note;
      logic [11:0] midi_time;
      logic [7:0]  entry_index;
      logic [6:0]  entry_trigger;
      logic        entry_skip;
      logic [2:0]  entry_note_count;
      logic [2:0]  note_slot;
      logic [6:0]  note_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_status;
      logic [6:0]  out_note;
      logic [6:0]  out_velocity;
      logic [11:0] out_time;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_HEADER,
      CMD_NOTE,
      CMD_MIDI
   } cmd_kind_type;

   // classified item handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   index;
      logic [6:0]   note;    // trigger, note value or incoming note
      logic         skip;
      logic [2:0]   count;   // already saturated
      logic [2:0]   slot;
      logic [11:0]  frame;
   } cmd_type;

   typedef struct packed {
      logic [6:0] trigger;
      logic       skip;
      logic [2:0] count;
   } hdr_type;

endpackage

/* sv/mcsf_ram.sv */
// ----------------------------------------------------------------------------
// MCSF generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mcsf_front.sv */
// ----------------------------------------------------------------------------
// MCSF front end
// Accepts input items, drops those with no effect, classifies the rest.
// ----------------------------------------------------------------------------
module mcsf_front
   import mcsf_pkg::*;
#(
   parameter int MAX_STEPS = 256,
   parameter int MAX_NOTES = 5
) (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   input  logic    clearing,
   output logic    push,
   output cmd_type push_data
);

   logic keep;
   logic index_ok;
   logic slot_ok;

   assign index_ok  = int'(req_data.entry_index) < MAX_STEPS;
   assign slot_ok   = int'(req_data.note_slot) < MAX_NOTES;
   assign req_ready = !queue_full && !clearing;
   assign push      = req_valid && req_ready && keep;

   always_comb begin
      keep            = 1'b0;
      push_data       = '0;
      push_data.kind  = CMD_MIDI;
      push_data.index = req_data.entry_index;
      push_data.slot  = req_data.note_slot;
      push_data.skip  = req_data.entry_skip;
      push_data.frame = 12'(req_data.midi_time % FRAME_LIMIT);
      // saturate the note count
      push_data.count = (int'(req_data.entry_note_count) > MAX_NOTES) ?
                        3'(MAX_NOTES) : req_data.entry_note_count;
      unique case (req_data.func)
         FUNC_HEADER: begin
            keep           = index_ok;
            push_data.kind = CMD_HEADER;
            push_data.note = req_data.entry_trigger;
         end
         FUNC_NOTE: begin
            keep           = index_ok && slot_ok;
            push_data.kind = CMD_NOTE;
            push_data.note = req_data.note_value;
         end
         FUNC_MIDI: begin
            keep           = (req_data.midi_status & STATUS_MASK) == NOTE_ON;
            push_data.kind = CMD_MIDI;
            push_data.note = req_data.midi_note;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

/* sv/mcsf_queue.sv */
// ----------------------------------------------------------------------------
// MCSF command queue
// Two-entry FIFO between front end and back end.
// ----------------------------------------------------------------------------
`include "midi_chord_step_follower_macros.svh"

module mcsf_queue
   import mcsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int DEPTH = 2;

   cmd_type    slots_ff [DEPTH];
   cmd_type    slots_in [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'(DEPTH);
   assign empty    = count_ff == 2'd0;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      slots_in  = slots_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         slots_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MCSF_ASSERT_NOW(a_no_overflow, clock, reset, push, !full)
   `MCSF_ASSERT_NOW(a_no_underflow, clock, reset, pop, !empty)

endmodule

/* sv/mcsf_back.sv */
// ----------------------------------------------------------------------------
// MCSF back end
// Owns the step tables, matches triggers and emits chord note events.
// ----------------------------------------------------------------------------
`include "midi_chord_step_follower_macros.svh"

module mcsf_back
   import mcsf_pkg::*;
#(
   parameter int MAX_STEPS = 256,
   parameter int MAX_NOTES = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [8:0] step_count,
   input  cmd_type    cmd,
   input  logic       empty,
   output logic       pop,
   output logic       clearing,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int STEP_W = $clog2(MAX_STEPS);
   localparam int NEXT_W = STEP_W + 1;
   localparam int CMP_W  = (NEXT_W > 9) ? NEXT_W : 9;
   localparam int SLOT_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int HDR_W  = $bits(hdr_type);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HDR,
      S_PREV,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  clr_ff, clr_in;
   logic [NEXT_W-1:0]  next_ff, next_in;
   logic [STEP_W-1:0]  prev_ff, prev_in;
   logic [2:0]         on_count_ff, on_count_in;
   logic [2:0]         off_count_ff, off_count_in;
   logic [11:0]        frame_ff, frame_in;
   logic [6:0]         trig_ff, trig_in;
   logic               phase_ff, phase_in;     // 0 note-offs, 1 note-ons
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic                     hdr_we;
   logic [STEP_W-1:0]        hdr_wa;
   hdr_type                  hdr_wd;
   logic [STEP_W-1:0]        hdr_ra;
   logic [HDR_W-1:0]         hdr_rd_raw;
   hdr_type                  hdr_rd;
   logic                     note_we;
   logic [STEP_W+SLOT_W-1:0] note_wa;
   logic [STEP_W+SLOT_W-1:0] note_ra;
   logic [6:0]               note_rd;

   logic [CMP_W-1:0] limit;
   logic             table_live;
   logic             out_free;
   logic             off_end;
   logic             on_end;
   logic             is_last;

   mcsf_ram #(.WIDTH(HDR_W), .DEPTH(MAX_STEPS)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_wa),
      .wr_data (hdr_wd),
      .rd_addr (hdr_ra),
      .rd_data (hdr_rd_raw)
   );

   mcsf_ram #(.WIDTH(7), .DEPTH(MAX_STEPS * (2 ** SLOT_W))) u_note_ram (
      .clock   (clock),
      .wr_en   (note_we),
      .wr_addr (note_wa),
      .wr_data (cmd.note),
      .rd_addr (note_ra),
      .rd_data (note_rd)
   );

   assign hdr_rd = hdr_type'(hdr_rd_raw);

   assign limit      = (CMP_W'(step_count) > CMP_W'(MAX_STEPS)) ?
                       CMP_W'(MAX_STEPS) : CMP_W'(step_count);
   assign table_live = CMP_W'(next_ff) < limit;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign off_end    = 4'(slot_ff) + 4'd1 == 4'(off_count_ff);
   assign on_end     = 4'(slot_ff) + 4'd1 == 4'(on_count_ff);
   assign is_last    = phase_ff ? on_end : (off_end && on_count_ff == 3'd0);

   // header read: next entry while idle, previous entry while checking the hit
   assign hdr_ra  = (state_ff == S_HDR) ? prev_ff : STEP_W'(next_ff);
   // note read follows the next slot so data lines up with the slot register
   assign note_ra = {(phase_in ? STEP_W'(next_ff) : prev_ff), slot_in};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_in      = next_ff;
      prev_in      = prev_ff;
      on_count_in  = on_count_ff;
      off_count_in = off_count_ff;
      frame_in     = frame_ff;
      trig_in      = trig_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      hdr_we       = 1'b0;
      hdr_wa       = STEP_W'(cmd.index);
      hdr_wd       = '{trigger: cmd.note, skip: cmd.skip, count: cmd.count};
      note_we      = 1'b0;
      note_wa      = {STEP_W'(cmd.index), SLOT_W'(cmd.slot)};

      unique case (state_ff)
         S_CLEAR: begin
            hdr_we = 1'b1;
            hdr_wa = clr_ff;
            hdr_wd = '0;
            clr_in = clr_ff + STEP_W'(1);
            if (clr_ff == STEP_W'(MAX_STEPS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               unique case (cmd.kind)
                  CMD_HEADER: begin
                     hdr_we = 1'b1;
                  end
                  CMD_NOTE: begin
                     note_we = 1'b1;
                  end
                  CMD_MIDI: begin
                     if (table_live) begin
                        frame_in = cmd.frame;
                        trig_in  = cmd.note;
                        state_in = S_HDR;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_HDR: begin
            priority if (hdr_rd.trigger != trig_ff) begin
               state_in = S_IDLE;
            end else if (hdr_rd.skip) begin
               next_in  = next_ff + NEXT_W'(1);
               state_in = S_IDLE;
            end else begin
               on_count_in = hdr_rd.count;
               state_in    = S_PREV;
            end
         end
         S_PREV: begin
            off_count_in = hdr_rd.count;
            slot_in      = '0;
            priority if (hdr_rd.count != 3'd0) begin
               phase_in = 1'b0;
               state_in = S_EMIT;
            end else if (on_count_ff != 3'd0) begin
               phase_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               prev_in  = STEP_W'(next_ff);
               next_in  = next_ff + NEXT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_status   = phase_ff ? OUT_NOTE_ON : OUT_NOTE_OFF;
               rsp_data_in.out_note     = note_rd;
               rsp_data_in.out_velocity = OUT_VELOCITY;
               rsp_data_in.out_time     = frame_ff;
               rsp_data_in.last         = is_last;
               priority if (is_last) begin
                  prev_in  = STEP_W'(next_ff);
                  next_in  = next_ff + NEXT_W'(1);
                  state_in = S_IDLE;
               end else if (!phase_ff && off_end) begin
                  phase_in = 1'b1;
                  slot_in  = '0;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      on_count_ff  <= on_count_in;
      off_count_ff <= off_count_in;
      frame_ff     <= frame_in;
      trig_ff      <= trig_in;
      phase_ff     <= phase_in;
      slot_ff      <= slot_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_ff      <= NEXT_W'(1);
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_ff      <= next_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign clearing  = state_ff == S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MCSF_ASSERT_NOW(a_next_nonzero, clock, reset, 1'b1, next_ff != '0)
   `MCSF_ASSERT_NOW(a_prev_below_next, clock, reset, 1'b1, CMP_W'(prev_ff) < CMP_W'(next_ff))
   `MCSF_ASSERT_NOW(a_no_pop_in_clear, clock, reset, state_ff == S_CLEAR, !pop)

endmodule

/* sv/midi_chord_step_follower.sv */
// ----------------------------------------------------------------------------
// MIDI chord step follower
// Plays a loaded list of chord steps, one step per matching MIDI note-on.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items: func selects a MIDI event, an entry header write
//   (trigger, skip mark, note count) or one entry note write.
//   rsp_* carries emitted MIDI events: note-offs for the previous chord, then
//   note-ons for the new one, last set on the final event of a step.
//   csr_* is an APB-style port holding step_count at byte address 0.
// Processing:
//   Items with no effect are dropped at the front. The back end takes a load
//   item or a note-on past the table in its idle state alone; a note-on that
//   reaches the table also checks the next entry's header, and a fired step
//   then reads the previous entry's header and emits its events in turn.
//   A two-entry queue lets the front keep taking items while the back works.
// Reset:
//   After reset the back end clears the header RAM, one entry per cycle, for all
//   MAX_STEPS entries; req_ready stays low during that pass. step_count resets
//   to one, the next step to one and the previous chord to the empty entry.
// Stalls:
//   A low rsp_ready holds the current event in the output register; a further
//   event pauses the back end, and the queue then fills and req_ready drops.
// ----------------------------------------------------------------------------
module midi_chord_step_follower
   import mcsf_pkg::*;
#(
   parameter int MAX_STEPS = 256,
   parameter int MAX_NOTES = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic [CSR_ADDR_W-3:0] REG_STEP_COUNT = '0;

   logic [8:0] step_count_ff, step_count_in;
   logic       csr_write;
   logic       csr_hit;

   logic    push;
   cmd_type push_data;
   logic    queue_full;
   logic    pop;
   cmd_type pop_data;
   logic    queue_empty;
   logic    clearing;

   // Register access: decode the word index, take writes in the access phase.
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_STEP_COUNT;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {23'd0, step_count_ff} : 32'd0;

   always_comb begin
      step_count_in = step_count_ff;
      if (csr_write && csr_hit) begin
         step_count_in = csr_pwdata[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RESET;
      end else begin
         step_count_ff <= step_count_in;
      end
   end

   // Front: accept, drop no-effect items, classify the rest.
   mcsf_front #(.MAX_STEPS(MAX_STEPS), .MAX_NOTES(MAX_NOTES)) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .clearing   (clearing),
      .push       (push),
      .push_data  (push_data)
   );

   // Queue: decouple intake from the table walk.
   mcsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // Back: own the tables, match triggers, emit chord events.
   mcsf_back #(.MAX_STEPS(MAX_STEPS), .MAX_NOTES(MAX_NOTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .step_count (step_count_ff),
      .cmd        (pop_data),
      .empty      (queue_empty),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* sim/tb_midi_chord_step_follower.sv */
// ----------------------------------------------------------------------------
// Testbench for midi_chord_step_follower
// Loads chord step tables through the item channel, plays note-on streams at
// the follower and checks every emitted note-off/note-on event, field by
// field, against an in-bench model of the step table. step_count is changed
// over the CSR port between phases, covering zero, one, 256 and 511.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midi_chord_step_follower;
   import mcsf_pkg::*;

   localparam int STEP_DEPTH    = 256;
   localparam int NOTE_SLOTS    = 5;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 50;

   // func code the block must ignore
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // plain note-off status, never fires a step
   localparam logic [7:0] NOTE_OFF_IN = 8'h80;
   localparam logic [CSR_ADDR_W-1:0] ADDR_STEP_COUNT = '0;

   // two copies of the table state: one runs ahead while items are generated,
   // the other follows the items the block has actually taken
   localparam int COPY_GEN = 0;
   localparam int COPY_DUT = 1;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // table model state
   bit [8:0] step_reg  [2];
   bit [8:0] next_step [2];
   bit [7:0] prev_step [2];
   bit [6:0] trig_mem  [2][STEP_DEPTH];
   bit       skip_mem  [2][STEP_DEPTH];
   bit [2:0] cnt_mem   [2][STEP_DEPTH];
   bit [6:0] note_mem  [2][STEP_DEPTH*NOTE_SLOTS];

   // which table words the stimulus has written so far
   bit hdr_known  [STEP_DEPTH];
   bit note_known [STEP_DEPTH*NOTE_SLOTS];

   req_type     item_q[$];
   rsp_type     pending_events[$];

   int unsigned items_queued;
   int unsigned items_taken;
   int unsigned phase_count;
   int unsigned steps_fired;
   int unsigned steps_skipped;
   int unsigned events_checked;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned req_gap;
   int unsigned rsp_gap;
   bit          req_taken;
   bit          calm;

   midi_chord_step_follower #(
      .MAX_STEPS (STEP_DEPTH),
      .MAX_NOTES (NOTE_SLOTS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial forever #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Table model
   // ------------------------------------------------------------------------

   // usable entries: counts above the table depth saturate
   function automatic int unsigned step_limit(int cp);
      return (step_reg[cp] > STEP_DEPTH) ? STEP_DEPTH : 32'(step_reg[cp]);
   endfunction

   // Apply one item to a copy of the table; for the copy that follows the
   // block, queue the chord events the item causes.
   function automatic void play_item(int cp, req_type it);
      int unsigned idx;
      int unsigned entry;
      int unsigned nx;
      rsp_type     evs[$];
      rsp_type     ev;
      idx = 32'(it.entry_index);
      case (it.func)
         FUNC_HEADER: begin
            if (idx < STEP_DEPTH) begin
               trig_mem[cp][idx] = it.entry_trigger;
               skip_mem[cp][idx] = it.entry_skip;
               cnt_mem[cp][idx]  = (it.entry_note_count > NOTE_SLOTS) ?
                                   3'(NOTE_SLOTS) : it.entry_note_count;
            end
         end
         FUNC_NOTE: begin
            if (idx < STEP_DEPTH && it.note_slot < NOTE_SLOTS)
               note_mem[cp][idx*NOTE_SLOTS + 32'(it.note_slot)] = it.note_value;
         end
         FUNC_MIDI: begin
            nx = 32'(next_step[cp]);
            if (nx < step_limit(cp) && (it.midi_status & STATUS_MASK) == NOTE_ON &&
                it.midi_note == trig_mem[cp][nx]) begin
               if (!skip_mem[cp][nx]) begin
                  // release the previous chord, then sound the new one
                  for (int pass = 0; pass < 2; pass++) begin
                     entry = (pass == 0) ? 32'(prev_step[cp]) : nx;
                     for (int s = 0; s < int'(cnt_mem[cp][entry]); s++) begin
                        ev.out_status   = (pass == 0) ? OUT_NOTE_OFF : OUT_NOTE_ON;
                        ev.out_note     = note_mem[cp][entry*NOTE_SLOTS + s];
                        ev.out_velocity = OUT_VELOCITY;
                        ev.out_time     = 12'(it.midi_time % FRAME_LIMIT);
                        ev.last         = 1'b0;
                        evs             = {evs, ev};
                     end
                  end
                  if (evs.size() != 0)
                     evs[evs.size()-1].last = 1'b1;
                  prev_step[cp] = nx[7:0];
                  if (cp == COPY_DUT)
                     steps_fired++;
               end else if (cp == COPY_DUT) begin
                  steps_skipped++;
               end
               next_step[cp] = next_step[cp] + 9'd1;
            end
         end
         default: ;
      endcase
      if (cp == COPY_DUT)
         pending_events = {pending_events, evs};
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // all fields random; callers overwrite the ones that matter
   function automatic req_type random_item();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return req_type'(r[$bits(req_type)-1:0]);
   endfunction

   function automatic void queue_item(req_type it);
      phase_count++;
      if (it.func == FUNC_HEADER)
         hdr_known[it.entry_index] = 1'b1;
      if (it.func == FUNC_NOTE && it.note_slot < NOTE_SLOTS)
         note_known[32'(it.entry_index)*NOTE_SLOTS + 32'(it.note_slot)] = 1'b1;
      item_q = {item_q, it};
      items_queued++;
      play_item(COPY_GEN, it);
   endfunction

   function automatic req_type midi_item(logic [7:0] status, logic [6:0] note,
                                         logic [11:0] frame);
      req_type it;
      it             = random_item();
      it.func        = FUNC_MIDI;
      it.midi_status = status;
      it.midi_note   = note;
      it.midi_time   = frame;
      return it;
   endfunction

   function automatic void write_note(int unsigned idx, logic [2:0] slot, logic [6:0] val);
      req_type it;
      it             = random_item();
      it.func        = FUNC_NOTE;
      it.entry_index = 8'(idx);
      it.note_slot   = slot;
      it.note_value  = val;
      queue_item(it);
   endfunction

   // Write a header, then fill any chord slot it uses that was never written,
   // so a fired step never reads an undefined note.
   function automatic void load_entry(int unsigned idx, logic [6:0] trig, logic skip,
                                      logic [2:0] cnt);
      req_type it;
      int      n;
      it                  = random_item();
      it.func             = FUNC_HEADER;
      it.entry_index      = 8'(idx);
      it.entry_trigger    = trig;
      it.entry_skip       = skip;
      it.entry_note_count = cnt;
      queue_item(it);
      n = (cnt > NOTE_SLOTS) ? NOTE_SLOTS : int'(cnt);
      for (int s = 0; s < n; s++)
         if (!note_known[idx*NOTE_SLOTS + s])
            write_note(idx, 3'(s), 7'($urandom_range(0, 127)));
   endfunction

   // the step about to be matched must hold a written header
   function automatic void ensure_header(int unsigned idx);
      if (!hdr_known[idx])
         load_entry(idx, 7'($urandom_range(0, 127)), $urandom_range(0, 3) == 0,
                    3'($urandom_range(0, 7)));
   endfunction

   // Mostly note-ons that hit the next trigger, mixed with table rewrites,
   // stray MIDI and ignored items.
   task automatic random_phase(int unsigned quota, bit pause_midway);
      int unsigned nx;
      bit          active;
      bit          paused;
      int          pick;
      logic [7:0]  status;
      req_type     it;
      phase_count = 0;
      paused      = 1'b0;
      while (phase_count < quota) begin
         nx     = 32'(next_step[COPY_GEN]);
         active = nx < step_limit(COPY_GEN);
         pick   = $urandom_range(0, 99);
         if (active && (pick < 65 || pick >= 96))
            ensure_header(nx);
         if (pick < 55 && active) begin
            queue_item(midi_item(NOTE_ON | 8'($urandom_range(0, 15)), trig_mem[COPY_GEN][nx],
                                 12'($urandom_range(0, 4095))));
         end else if (pick < 65) begin
            queue_item(midi_item(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                                 12'($urandom_range(0, 4095))));
         end else if (pick < 78) begin
            // rewrite an upcoming step or any entry at all
            load_entry($urandom_range(0, 1) ? (nx + $urandom_range(0, 3)) % STEP_DEPTH :
                                              $urandom_range(0, STEP_DEPTH - 1),
                       7'($urandom_range(0, 127)), $urandom_range(0, 3) == 0,
                       3'($urandom_range(0, 7)));
         end else if (pick < 92) begin
            write_note($urandom_range(0, STEP_DEPTH - 1), 3'($urandom_range(0, 7)),
                       7'($urandom_range(0, 127)));
         end else if (pick < 96) begin
            it      = random_item();
            it.func = FUNC_UNUSED;
            queue_item(it);
         end else begin
            // anything but a note-on
            status = 8'($urandom_range(0, 255));
            if ((status & STATUS_MASK) == NOTE_ON)
               status = status ^ 8'h10;
            queue_item(midi_item(status, 7'($urandom_range(0, 127)),
                                 12'($urandom_range(0, 4095))));
         end
         if (pause_midway && !paused && phase_count >= quota / 2) begin
            // hold the sender until the block has answered everything
            paused = 1'b1;
            wait_drained(1'b0);
         end
      end
   endtask

   // Wait until every item is taken and every event has come back; optionally
   // let trailing items with no events finish inside the block.
   task automatic wait_drained(bit settle);
      do
         @(negedge clock);
      while (items_taken != items_queued || pending_events.size() != 0);
      if (settle)
         repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // ------------------------------------------------------------------------
   // CSR access
   // ------------------------------------------------------------------------

   task automatic read_steps(logic [8:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_STEP_COUNT;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_field("csr_pready", 32'(csr_pready), 32'd1);
      check_field("step_count readback", csr_prdata, {23'd0, want});
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_steps(logic [8:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_STEP_COUNT;
      csr_pwdata  <= {23'd0, val};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      step_reg[COPY_GEN] = val;
      step_reg[COPY_DUT] = val;
      read_steps(val);
   endtask

   // ------------------------------------------------------------------------
   // Driver: change inputs on the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      // hold the current item until taken, then idle or present the next one
      if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (item_q.size() != 0) begin
            req_data  <= item_q.pop_front();
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
      // stall the result side in bursts
      if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 4) == 0)
            rsp_gap = $urandom_range(1, 7);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample handshakes on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // check the event first: it can only belong to an earlier item
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               report_error($sformatf("unexpected event: status 0x%0h note %0d",
                                      rsp_data.out_status, rsp_data.out_note));
            end else begin
               want = pending_events.pop_front();
               check_field("out_status", 32'(rsp_data.out_status), 32'(want.out_status));
               check_field("out_note", 32'(rsp_data.out_note), 32'(want.out_note));
               check_field("out_velocity", 32'(rsp_data.out_velocity),
                           32'(want.out_velocity));
               check_field("out_time", 32'(rsp_data.out_time), 32'(want.out_time));
               check_field("last", 32'(rsp_data.last), 32'(want.last));
            end
            events_checked++;
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            items_taken++;
            play_item(COPY_DUT, req_data);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int cp = 0; cp < 2; cp++) begin
         step_reg[cp]  = STEP_COUNT_RESET;
         next_step[cp] = 9'd1;
         prev_step[cp] = 8'd0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset value; step count one means the table is already used up
      read_steps(STEP_COUNT_RESET);
      queue_item(midi_item(NOTE_ON, 7'd0, 12'd0));
      queue_item(midi_item(NOTE_ON | 8'h0f, 7'd127, 12'd4095));
      wait_drained(1'b1);

      // step count zero: MIDI ignored as well
      write_steps(9'd0);
      queue_item(midi_item(NOTE_ON, 7'd0, 12'd1));
      wait_drained(1'b1);

      // Directed table: entry 0 overwritten with a two-note start chord,
      // a saturated note count, out-of-range slots, a skip step and empty
      // chords on both sides of a step.
      write_steps(9'd6);
      write_note(0, 3'd0, 7'h11);
      write_note(0, 3'd1, 7'h7f);
      load_entry(0, 7'd5, 1'b0, 3'd2);
      write_note(1, 3'd0, 7'd0);
      write_note(1, 3'd1, 7'd127);
      write_note(1, 3'd2, 7'd64);
      write_note(1, 3'd3, 7'd1);
      write_note(1, 3'd4, 7'd126);
      write_note(1, 3'd5, 7'd3);
      write_note(1, 3'd7, 7'd9);
      load_entry(1, 7'd60, 1'b0, 3'd7);
      load_entry(2, 7'd127, 1'b1, 3'd0);
      load_entry(3, 7'd0, 1'b0, 3'd0);
      load_entry(4, 7'd0, 1'b0, 3'd0);
      write_note(5, 3'd0, 7'd45);
      load_entry(5, 7'd33, 1'b0, 3'd1);
      queue_item(midi_item(NOTE_OFF_IN, 7'd60, 12'd100));       // not a note-on
      queue_item(midi_item(NOTE_ON, 7'd61, 12'd200));           // wrong note
      queue_item(midi_item(NOTE_ON | 8'h0f, 7'd60, 12'd4095));  // fire entry 1
      queue_item('{func: FUNC_UNUSED, default: '1});
      queue_item(midi_item(NOTE_ON | 8'h03, 7'd127, 12'd7));    // skip entry 2
      queue_item(midi_item(NOTE_ON, 7'd0, 12'd0));              // offs only
      queue_item(midi_item(NOTE_ON | 8'h0a, 7'd0, 12'd2048));   // empty to empty
      queue_item(midi_item(NOTE_ON, 7'd33, 12'd1));             // ons only
      queue_item(midi_item(NOTE_ON, 7'd5, 12'd3));              // table used up
      wait_drained(1'b1);

      // random phases, each opening a few more steps past the current one
      for (int ph = 0; ph < 4; ph++) begin
         write_steps(9'(next_step[COPY_GEN] + $urandom_range(3, 14)));
         random_phase(25, ph == 1);
         wait_drained(1'b1);
      end

      // register above the table depth acts as the full table
      write_steps(9'd511);
      random_phase(15, 1'b0);
      wait_drained(1'b1);

      // step count below the current step: MIDI ignored, loads still land
      write_steps(9'd2);
      random_phase(6, 1'b0);
      wait_drained(1'b1);

      // full table, no idling on either side
      calm = 1'b1;
      write_steps(9'd256);
      random_phase(15, 1'b0);
      wait_drained(1'b1);

      $display("Covered %0d items: %0d steps fired, %0d skipped, %0d events checked",
               items_taken, steps_fired, steps_skipped, events_checked);
      $display("Step counts 0, 1, 256, 511 and random; follower ended at step %0d",
               next_step[COPY_DUT]);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
